/* src/nev_pkg.sv */
// Package: shared constants, types and helpers of the Neville interpolator
package nev_pkg;

    localparam int MaxPoints = 8;
    localparam int IdxW      = $clog2(MaxPoints);
    localparam int CntW      = $clog2(MaxPoints + 1);

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_OVF  = 2'd2,
        ST_SAT  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DIFF,
        S_MUL,
        S_SUB,
        S_START,
        S_WAIT,
        S_SHIFT,
        S_FIN,
        S_OUT
    } state_t;

    function automatic logic signed [31:0] clamp33(input logic signed [32:0] v,
                                                   output logic sat);
        logic signed [31:0] r;
        sat = 1'b0;
        r = v[31:0];
        if (v > 33'sd2147483647)
        begin
            sat = 1'b1;
            r = 32'sh7FFFFFFF;
        end
        else if (v < -33'sd2147483648)
        begin
            sat = 1'b1;
            r = 32'sh80000000;
        end
        return r;
    endfunction

endpackage

/* src/nev_cell.sv */
// Row cell: holds one abscissa and one tableau entry, shifts with its neighbour
module nev_cell (
    input  logic                clk,
    input  logic                shift,
    input  logic signed [31:0]  x_in,
    input  logic signed [31:0]  q_in,
    input  logic signed [31:0]  probe,
    input  logic                armed,
    output logic signed [31:0]  x_out,
    output logic signed [31:0]  q_out,
    output logic                hit
);
    import nev_pkg::*;

    logic signed [31:0] x_reg;
    logic signed [31:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            x_reg <= x_in;
            q_reg <= q_in;
        end
    end

    assign x_out = x_reg;
    assign q_out = q_reg;
    assign hit = armed && (x_reg == probe);
endmodule

/* src/nev_div.sv */
// Serial restoring divider: 65-bit magnitude by 33-bit magnitude, one bit a cycle
module nev_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [64:0]   num,
    input  logic [32:0]   den,
    output logic          done,
    output logic [64:0]   quo
);
    import nev_pkg::*;

    logic [64:0] q_reg, q_next;
    logic [33:0] r_reg, r_next;
    logic [6:0]  n_reg, n_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [33:0] trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        n_next = n_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {r_reg[32:0], q_reg[64]} - {1'b0, den};
        if (start)
        begin
            q_next = num;
            r_next = '0;
            n_next = 7'd65;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[33])
            begin
                r_next = trial;
                q_next = {q_reg[63:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[32:0], q_reg[64]};
                q_next = {q_reg[63:0], 1'b0};
            end
            n_next = n_reg - 7'd1;
            if (n_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            n_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            n_reg <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign done = done_reg;
    assign quo = q_reg;
endmodule

/* src/neville_interpolator.sv */
// Top level: Neville interpolator with a shifting row of tableau cells
// Words are taken one at a time. Every new tableau entry of a word but its own point_y
// passes through the one serial divider, after the steps of differences, products and
// subtraction. Both cell rows shift once per step, eight steps for each accepted word,
// so abscissa x_(i-j) and entry Q[i-1][j-1] always sit in the head cell while the new
// row and abscissa refill from the tail. A rejected or ignored word goes from the check
// straight to the finish state. A last word then waits in the output state while the
// previous result is still unaccepted and then loads the output register; no input is
// taken meanwhile.
module neville_interpolator (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [95:0]   s_tdata,   // query_x, point_x, point_y
    input  logic          s_tlast,   // last_point
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [39:0]   m_tdata    // value, points_used, status, zero pad
);
    import nev_pkg::*;

    state_t state_reg, state_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [IdxW-1:0] k_reg, k_next;
    status_t err_reg, err_next;
    logic signed [31:0] hq_reg, hq_next;
    logic signed [31:0] px_reg, px_next;
    logic signed [31:0] py_reg, py_next;
    logic last_reg, last_next;
    logic signed [31:0] xd_reg, xd_next;
    logic signed [31:0] r_reg, r_next;
    logic sat_reg, sat_next;
    logic signed [31:0] d1_reg, d1_next;
    logic signed [31:0] d2_reg, d2_next;
    logic signed [32:0] den_reg, den_next;
    logic signed [63:0] p1_reg, p1_next;
    logic signed [63:0] p2_reg, p2_next;
    logic [64:0] diff_reg, diff_next;
    logic [39:0] out_reg, out_next;
    logic ov_reg, ov_next;

    logic shift;
    logic signed [31:0] cx [MaxPoints];
    logic signed [31:0] cq [MaxPoints];
    logic [MaxPoints-1:0] hits;
    logic signed [31:0] head_x, head_q;
    logic dup;

    logic dstart, ddone;
    logic [64:0] dnum, dquo;
    logic [32:0] dden;
    logic neg;

    logic in_acc;
    logic s1, s2;
    logic signed [31:0] d1c, d2c;
    logic signed [32:0] den_w;
    logic signed [31:0] qv;
    logic qsat;
    logic entry_due;
    logic out_free;
    logic signed [31:0] res_value;

    assign head_x = cx[0];
    assign head_q = cq[0];
    assign dup = |hits;

    genvar g;
    generate
        for (g = 0; g < MaxPoints; g++)
        begin : g_cell
            logic signed [31:0] xi, qi;
            logic armed;
            if (g == MaxPoints - 1)
            begin : g_tail
                assign xi = xd_reg;
                assign qi = r_reg;
            end
            else
            begin : g_mid
                assign xi = cx[g+1];
                assign qi = cq[g+1];
            end
            assign armed = CntW'(g) < cnt_reg;
            nev_cell u_cell (
                .clk   (clk),
                .shift (shift),
                .x_in  (xi),
                .q_in  (qi),
                .probe (px_reg),
                .armed (armed),
                .x_out (cx[g]),
                .q_out (cq[g]),
                .hit   (hits[g])
            );
        end
    endgenerate

    nev_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dstart),
        .num   (dnum),
        .den   (dden),
        .done  (ddone),
        .quo   (dquo)
    );

    assign in_acc = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ov_reg;
    assign m_tdata = out_reg;
    assign out_free = !ov_reg || m_tready;
    assign entry_due = CntW'(k_reg) < cnt_reg;
    assign res_value = (err_reg == ST_OK || err_reg == ST_SAT) ? r_reg : '0;

    always_comb
    begin
        d1c = clamp33({hq_reg[31], hq_reg} - {head_x[31], head_x}, s1);
        d2c = clamp33({hq_reg[31], hq_reg} - {px_reg[31], px_reg}, s2);
    end
    assign den_w = {px_reg[31], px_reg} - {head_x[31], head_x};

    assign neg = diff_reg[64] ^ den_reg[32];
    assign dnum = diff_reg[64] ? -diff_reg : diff_reg;
    assign dden = den_reg[32] ? -den_reg : den_reg;
    assign dstart = (state_reg == S_START);

    always_comb
    begin
        qsat = 1'b0;
        qv = dquo[31:0];
        if (neg)
        begin
            if (dquo > 65'h80000000)
            begin
                qsat = 1'b1;
                qv = 32'sh80000000;
            end
            else
                qv = -dquo[31:0];
        end
        else if (dquo > 65'h7FFFFFFF)
        begin
            qsat = 1'b1;
            qv = 32'sh7FFFFFFF;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_acc)
                    state_next = S_CHECK;
            S_CHECK:
                if (err_reg == ST_DUP || err_reg == ST_OVF
                    || cnt_reg == CntW'(MaxPoints) || dup)
                    state_next = S_FIN;
                else if (cnt_reg == '0)
                    state_next = S_SHIFT;
                else
                    state_next = S_DIFF;
            S_DIFF:
                state_next = S_MUL;
            S_MUL:
                state_next = S_SUB;
            S_SUB:
                state_next = S_START;
            S_START:
                state_next = S_WAIT;
            S_WAIT:
                if (ddone)
                    state_next = S_SHIFT;
            S_SHIFT:
                if (k_reg == IdxW'(MaxPoints - 1))
                    state_next = S_FIN;
                else if (CntW'(k_reg) + CntW'(1) < cnt_reg)
                    state_next = S_DIFF;
                else
                    state_next = S_SHIFT;
            S_FIN:
                state_next = last_reg ? S_OUT : S_IDLE;
            S_OUT:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        k_next = k_reg;
        err_next = err_reg;
        hq_next = hq_reg;
        px_next = px_reg;
        py_next = py_reg;
        last_next = last_reg;
        xd_next = xd_reg;
        r_next = r_reg;
        sat_next = sat_reg;
        d1_next = d1_reg;
        d2_next = d2_reg;
        den_next = den_reg;
        p1_next = p1_reg;
        p2_next = p2_reg;
        diff_next = diff_reg;
        out_next = out_reg;
        ov_next = ov_reg && !m_tready;
        shift = 1'b0;
        case (state_reg)
            S_IDLE:
                if (in_acc)
                begin
                    px_next = s_tdata[63:32];
                    py_next = s_tdata[95:64];
                    last_next = s_tlast;
                    if (cnt_reg == '0)
                        hq_next = s_tdata[31:0];
                end
            S_CHECK:
                if (err_reg != ST_DUP && err_reg != ST_OVF)
                begin
                    if (cnt_reg == CntW'(MaxPoints))
                        err_next = ST_OVF;
                    else if (dup)
                        err_next = ST_DUP;
                    else
                    begin
                        k_next = '0;
                        r_next = py_reg;
                        xd_next = px_reg;
                        sat_next = 1'b0;
                    end
                end
            S_DIFF:
            begin
                d1_next = d1c;
                d2_next = d2c;
                den_next = den_w;
                sat_next = sat_reg | s1 | s2;
            end
            S_MUL:
            begin
                p1_next = 64'(d1_reg) * 64'(r_reg);
                p2_next = 64'(d2_reg) * 64'(head_q);
            end
            S_SUB:
                diff_next = {p1_reg[63], p1_reg} - {p2_reg[63], p2_reg};
            S_SHIFT:
            begin
                shift = 1'b1;
                xd_next = head_x;
                if (entry_due)
                begin
                    r_next = qv;
                    sat_next = sat_reg | qsat;
                end
                if (k_reg == IdxW'(MaxPoints - 1))
                begin
                    cnt_next = cnt_reg + CntW'(1);
                    if (sat_reg && err_reg == ST_OK)
                        err_next = ST_SAT;
                end
                else
                    k_next = k_reg + IdxW'(1);
            end
            S_OUT:
                if (out_free)
                begin
                    out_next = {2'b00, err_reg, cnt_reg, res_value};
                    ov_next = 1'b1;
                    cnt_next = '0;
                    err_next = ST_OK;
                end
            default:
                shift = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            err_reg <= ST_OK;
            hq_reg <= '0;
            ov_reg <= 1'b0;
            k_reg <= '0;
            sat_reg <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            err_reg <= err_next;
            hq_reg <= hq_next;
            ov_reg <= ov_next;
            k_reg <= k_next;
            sat_reg <= sat_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg <= px_next;
        py_reg <= py_next;
        xd_reg <= xd_next;
        r_reg <= r_next;
        d1_reg <= d1_next;
        d2_reg <= d2_next;
        den_reg <= den_next;
        p1_reg <= p1_next;
        p2_reg <= p2_next;
        diff_reg <= diff_next;
        out_reg <= out_next;
    end
endmodule

/* tb/neville_interpolator_test.sv */
// Testbench: Neville interpolator checked word by word against its own tableau predictor
module neville_interpolator_test;
    timeunit 1ns;
    timeprecision 1ps;
    import nev_pkg::*;

    localparam int  LIMIT = 5000000;
    localparam int  RANDOM_POINTS = 1200;
    localparam int  QUIET_POINTS = 150;

    typedef struct packed {
        logic signed [31:0] value;
        logic [3:0]         used;
        status_t            status;
    } result_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [95:0]   s_tdata = '0;   // query_x, point_x, point_y
    logic          s_tlast = 1'b0; // last_point
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [39:0]   m_tdata;        // value, points_used, status, zero pad

    result_t            expected_results[$];
    logic signed [31:0] entered_x[MaxPoints];
    logic signed [31:0] tableau_row[MaxPoints];
    int unsigned        entered_count = 0;
    logic signed [31:0] set_query = '0;
    status_t            set_status = ST_OK;

    int  mismatches = 0;
    int  points_sent = 0;
    int  hold_off = 0;
    bit  quiet = 1'b0;
    longint cycles = 0;

    neville_interpolator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v, inout bit sat);
        if (v > 66'sd2147483647)
        begin
            sat = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -66'sd2147483648)
        begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // advance the tableau by one accepted point and, on a last point, queue the set's result word
    function automatic void tableau_point(input logic signed [31:0] qx,
                                          input logic signed [31:0] px,
                                          input logic signed [31:0] py,
                                          input bit last);
        logic signed [31:0] row[MaxPoints];
        logic signed [65:0] den, d1, d2, num;
        bit dup, sat;
        int unsigned n;
        result_t r;
        dup = 1'b0;
        sat = 1'b0;
        n = entered_count;
        if (entered_count == 0)
            set_query = qx;
        if (set_status == ST_DUP || set_status == ST_OVF)
        begin
        end
        else if (entered_count >= MaxPoints)
            set_status = ST_OVF;
        else
        begin
            row[0] = py;
            for (int j = 1; j <= n; j++)
            begin
                den = 66'(px) - 66'(entered_x[n - j]);
                if (den == 0)
                begin
                    dup = 1'b1;
                    break;
                end
                d1 = 66'(sat32(66'(set_query) - 66'(entered_x[n - j]), sat));
                d2 = 66'(sat32(66'(set_query) - 66'(px), sat));
                num = d1 * 66'(row[j - 1]) - d2 * 66'(tableau_row[j - 1]);
                row[j] = sat32(num / den, sat);
            end
            if (dup)
                set_status = ST_DUP;
            else
            begin
                for (int j = 0; j <= n; j++)
                    tableau_row[j] = row[j];
                entered_x[n] = px;
                entered_count = n + 1;
                if (sat && set_status == ST_OK)
                    set_status = ST_SAT;
            end
        end
        if (last)
        begin
            r.value = '0;
            if ((set_status == ST_OK || set_status == ST_SAT) && entered_count > 0)
                r.value = tableau_row[entered_count - 1];
            r.used = entered_count[3:0];
            r.status = set_status;
            expected_results.push_back(r);
            entered_count = 0;
            set_status = ST_OK;
        end
    endfunction

    task automatic send_point(input logic signed [31:0] qx, input logic signed [31:0] px,
                              input logic signed [31:0] py, input bit last);
        if (!quiet && $urandom_range(3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {py, px, qx};
        s_tlast <= last;
        do
            @(posedge clk);
        while (!s_tready);
        tableau_point(qx, px, py, last);
        points_sent++;
    endtask

    task automatic finish_sending();
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;
    endtask

    // set of n points with distinct abscissas near the query
    task automatic send_clean_set(input int n);
        logic signed [31:0] xs[$];
        logic signed [31:0] qx, px;
        bit clash;
        qx = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
        for (int k = 0; k < n; k++)
        begin
            do
            begin
                px = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
                clash = 1'b0;
                foreach (xs[m])
                    if (xs[m] == px)
                        clash = 1'b1;
            end
            while (clash);
            xs.push_back(px);
            send_point(qx, px, $signed($urandom_range(0, 1 << 21)) - (1 << 20), k == n - 1);
        end
    endtask

    task automatic test_single_points();
        send_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 1'b1);
        send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
    endtask

    task automatic test_extremes();
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
        send_point(32'sh0000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
        send_point(32'sh8000_0000, 32'sh0000_0001, 32'sh7FFF_FFFF, 1'b0);
        send_point(32'sh0000_0000, 32'sh0000_0000, 32'sh7FFF_FFFF, 1'b0);
        send_point(32'sh0000_0000, 32'shFFFF_FFFF, 32'sh8000_0000, 1'b1);
    endtask

    task automatic test_duplicate();
        send_point(32'sh0000_8000, 32'sh0001_0000, 32'sh0002_0000, 1'b0);
        send_point(32'sh0000_0000, 32'sh0001_0000, 32'sh0005_0000, 1'b0);
        send_point(32'sh0000_0000, 32'sh0003_0000, 32'sh0005_0000, 1'b1);
    endtask

    task automatic test_overflow();
        for (int k = 0; k < MaxPoints + 2; k++)
            send_point(32'sh0000_4000, 32'(k) <<< 16, 32'(k * k) <<< 14, k == MaxPoints + 1);
    endtask

    task automatic test_query_hold();
        send_point(32'sh0002_8000, 32'sh0001_0000, 32'sh0001_0000, 1'b0);
        send_point(32'sh7FFF_0000, 32'sh0002_0000, 32'sh0004_0000, 1'b0);
        send_point(32'sh8000_0000, 32'sh0003_0000, 32'sh0009_0000, 1'b1);
        send_clean_set(MaxPoints);
    endtask

    task automatic test_backpressure();
        hold_off = 3000;
        for (int k = 0; k < 6; k++)
            send_clean_set(1 + k % 2);
    endtask

    task automatic test_random();
        int n;
        while (points_sent < RANDOM_POINTS)
        begin
            if (points_sent > RANDOM_POINTS - QUIET_POINTS)
                quiet = 1'b1;
            case ($urandom_range(9))
                0:
                begin
                    n = $urandom_range(1, MaxPoints + 2);
                    for (int k = 0; k < n; k++)
                        send_point($urandom, $urandom, $urandom, k == n - 1);
                end
                1:
                begin
                    n = $urandom_range(2, 5);
                    for (int k = 0; k < n; k++)
                        send_point($urandom, $signed($urandom_range(0, 3)) <<< 16,
                                   $urandom, k == n - 1);
                end
                2:
                    send_clean_set($urandom_range(MaxPoints + 1, MaxPoints + 3));
                default:
                    send_clean_set($urandom_range(1, MaxPoints));
            endcase
        end
    endtask

    // result checker and receiver idling
    initial
    begin
        result_t got, want;
        int idle_left;
        idle_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got = result_t'({m_tdata[31:0], m_tdata[35:32], m_tdata[37:36]});
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: value %h used %0d status %0d",
                                 got.value, got.used, got.status);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.value !== want.value || got.used !== want.used
                        || got.status !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("word mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                                     want.value, want.used, want.status,
                                     got.value, got.used, got.status);
                    end
                end
            end
            if (hold_off > 0)
            begin
                hold_off--;
                m_tready <= 1'b0;
            end
            else if (idle_left > 0)
            begin
                idle_left--;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(4) == 0)
            begin
                idle_left = $urandom_range(0, 4);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("neville_interpolator: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_single_points();
        test_extremes();
        test_duplicate();
        test_overflow();
        test_query_hold();
        test_backpressure();
        test_random();
        finish_sending();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("neville_interpolator: match");
        else
            $display("neville_interpolator: mismatch");
        $finish;
    end

endmodule

/* sim.f */
src/nev_pkg.sv
src/nev_cell.sv
src/nev_div.sv
src/neville_interpolator.sv
tb/neville_interpolator_test.sv
